// ----- rtl/core/tvpa_pkg.sv -----
// Shared types and constants for the thermal video packet assembler.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none

package tvpa_pkg;

  // Packet geometry.
  localparam logic [7:0]  PKT_BYTES      = 8'd164;
  localparam logic [7:0]  HDR_BYTES      = 8'd4;
  localparam logic [7:0]  LINE_PIXELS    = 8'd80;
  localparam logic [6:0]  SEG_ROWS       = 7'd30;
  localparam logic [14:0] FRAME_COLS     = 15'd160;
  localparam logic [5:0]  SEG_CHECK_LINE = 6'd20;
  localparam logic [5:0]  LINE_COUNT     = 6'd60;
  localparam logic [3:0]  DISCARD_NIBBLE = 4'hF;
  localparam logic [15:0] MIN_CLEAR      = 16'hFFFF;

  // Packet status codes.
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_DISCARD     = 3'd1,
    ST_LINE        = 3'd2,
    ST_SEGZERO     = 3'd3,
    ST_SEGMISMATCH = 3'd4,
    ST_ZEROPIX     = 3'd5
  } status_t;

  // One pixel handed from the parser to the extremes tracker.
  typedef struct packed {
    logic        go;
    logic [15:0] value;
    logic [7:0]  col;
    logic [6:0]  row;
  } pix_req_t;

  // Per-byte result from the parser.
  typedef struct packed {
    logic        emit;
    logic        pixel_valid;
    logic [14:0] addr;
    logic [15:0] value;
    logic        done;
    status_t     status;
  } parse_res_t;

  // Running extremes after this byte's update.
  typedef struct packed {
    logic [15:0] max_value;
    logic [7:0]  max_col;
    logic [6:0]  max_row;
    logic [15:0] min_value;
    logic [7:0]  min_col;
    logic [6:0]  min_row;
  } track_t;

endpackage

`default_nettype wire

// ----- rtl/core/tvpa_parse.sv -----
// Packet parser: byte counter, header checks and pixel assembly with addressing.
// Depends on tvpa_pkg.
`default_nettype none

module tvpa_parse import tvpa_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       acc,
  input  wire logic [7:0] byte_value,
  input  wire logic       first_of_packet,
  input  wire logic [5:0] expected_line,
  input  wire logic [2:0] expected_segment,
  output pix_req_t        pix,
  output parse_res_t      res
);

  logic [7:0] byte_index_r, byte_index_nxt;
  logic [7:0] header_first_r, header_first_nxt;
  logic [5:0] line_r, line_nxt;
  logic [2:0] seg_r, seg_nxt;
  status_t    status_r, status_nxt;
  logic       stop_r, stop_nxt;
  logic [7:0] high_r, high_nxt;

  logic [7:0]  idx;
  logic        active;
  logic [7:0]  p;
  logic [1:0]  slot;
  logic [7:0]  col;
  logic [6:0]  row;
  logic [15:0] v;
  logic        pix_go;
  logic [3:0]  nib;

  // A first-of-packet mark restarts the packet before the byte is handled.
  always_comb begin
    idx    = first_of_packet ? 8'd0 : byte_index_r;
    active = (idx < PKT_BYTES);
    p      = idx - HDR_BYTES;
    nib    = header_first_r[7:4];

    line_nxt   = first_of_packet ? expected_line : line_r;
    seg_nxt    = first_of_packet ? expected_segment : seg_r;
    status_nxt = first_of_packet ? ST_OK : status_r;
    stop_nxt   = first_of_packet ? 1'b0 : stop_r;
    high_nxt   = first_of_packet ? 8'd0 : high_r;
    header_first_nxt = header_first_r;
    byte_index_nxt   = active ? idx + 8'd1 : idx;

    // Frame position from line parity, line and segment slot.
    slot = seg_nxt[1:0] - 2'd1;
    col  = {1'b0, p[7:1]} + (line_nxt[0] ? LINE_PIXELS : 8'd0);
    row  = {5'd0, slot} * SEG_ROWS + {2'd0, line_nxt[5:1]};
    v    = {high_nxt, byte_value};

    pix_go = 1'b0;

    if (active) begin
      if (idx == 8'd0) begin
        header_first_nxt = byte_value;
        if (byte_value[3:0] == DISCARD_NIBBLE) begin
          status_nxt = ST_DISCARD;
        end
      end else if (idx == 8'd1) begin
        if (status_nxt == ST_OK) begin
          if (byte_value != {2'd0, line_nxt} || line_nxt >= LINE_COUNT) begin
            status_nxt = ST_LINE;
          end else if (line_nxt == SEG_CHECK_LINE) begin
            if (nib == 4'd0) begin
              status_nxt = ST_SEGZERO;
            end else if (nib != {1'b0, seg_nxt}) begin
              status_nxt = ST_SEGMISMATCH;
            end
          end
        end
      end else if (idx >= HDR_BYTES) begin
        if (!p[0]) begin
          high_nxt = byte_value;
        end else if (status_nxt == ST_OK && !stop_nxt) begin
          pix_go = 1'b1;
          if (v == 16'd0) begin
            stop_nxt   = 1'b1;
            status_nxt = ST_ZEROPIX;
          end
        end
      end
    end

    pix.go    = acc && pix_go;
    pix.value = v;
    pix.col   = col;
    pix.row   = row;

    res.pixel_valid = pix_go && (v != 16'd0);
    res.addr        = res.pixel_valid ? ({8'd0, row} * FRAME_COLS + {7'd0, col}) : 15'd0;
    res.value       = res.pixel_valid ? v : 16'd0;
    res.done        = active && (idx == PKT_BYTES - 8'd1);
    res.status      = status_nxt;
    res.emit        = acc && (res.pixel_valid || res.done);
  end

  // Packet state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r   <= 8'd0;
      header_first_r <= 8'd0;
      line_r         <= 6'd0;
      seg_r          <= 3'd1;
      status_r       <= ST_OK;
      stop_r         <= 1'b0;
      high_r         <= 8'd0;
    end else if (acc) begin
      byte_index_r   <= byte_index_nxt;
      header_first_r <= header_first_nxt;
      line_r         <= line_nxt;
      seg_r          <= seg_nxt;
      status_r       <= status_nxt;
      stop_r         <= stop_nxt;
      high_r         <= high_nxt;
    end
  end

  // The counter saturates one past the last byte.
  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    byte_index_r <= PKT_BYTES)
    else $error("byte counter ran past the packet end");

  // Stopping on a zero pixel always leaves the zero-pixel status behind.
  a_stop_status: assert property (@(posedge clk) disable iff (!rst_n)
    stop_r |-> status_r == ST_ZEROPIX)
    else $error("pixel stop without zero-pixel status");

  // A frame write only comes from a packet that is still good.
  a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
    res.pixel_valid |-> res.status == ST_OK)
    else $error("pixel write from a rejected packet");

endmodule

`default_nettype wire

// ----- rtl/core/tvpa_track.sv -----
// Running maximum and minimum pixel of the frame with their coordinates.
// Depends on tvpa_pkg.
`default_nettype none

module tvpa_track import tvpa_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     clear,
  input  wire pix_req_t pix,
  output track_t        trk
);

  track_t cur_r, cur_nxt, base;

  // Clearing happens before this byte's pixel is compared.
  always_comb begin
    if (clear) begin
      base.max_value = 16'd0;
      base.max_col   = 8'd0;
      base.max_row   = 7'd0;
      base.min_value = MIN_CLEAR;
      base.min_col   = 8'd0;
      base.min_row   = 7'd0;
    end else begin
      base = cur_r;
    end
    cur_nxt = base;
    if (pix.go && pix.value > base.max_value) begin
      cur_nxt.max_value = pix.value;
      cur_nxt.max_col   = pix.col;
      cur_nxt.max_row   = pix.row;
    end
    if (pix.go && pix.value < base.min_value) begin
      cur_nxt.min_value = pix.value;
      cur_nxt.min_col   = pix.col;
      cur_nxt.min_row   = pix.row;
    end
    trk = cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r.max_value <= 16'd0;
      cur_r.max_col   <= 8'd0;
      cur_r.max_row   <= 7'd0;
      cur_r.min_value <= MIN_CLEAR;
      cur_r.min_col   <= 8'd0;
      cur_r.min_row   <= 7'd0;
    end else begin
      cur_r <= cur_nxt;
    end
  end

  // Either nothing seen since the clear, or the maximum is not below the minimum.
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_r.max_value >= cur_r.min_value) ||
    (cur_r.max_value == 16'd0 && cur_r.min_value == MIN_CLEAR))
    else $error("running maximum fell below running minimum");

  // A pixel above the old maximum leaves the maximum at that pixel.
  a_max_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (pix.go && !clear && pix.value > cur_r.max_value) |=> cur_r.max_value == $past(pix.value))
    else $error("maximum missed a larger pixel");

  // Clearing without a pixel returns the tracker to its reset values.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (clear && !pix.go) |=> (cur_r.max_value == 16'd0 && cur_r.min_value == MIN_CLEAR))
    else $error("clear did not reset the extremes");

endmodule

`default_nettype wire

// ----- rtl/core/tvpa_out.sv -----
// Result register of the assembler: holds one result and drives the stream handshake.
// Depends on tvpa_pkg.
`default_nettype none

module tvpa_out import tvpa_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire parse_res_t res,
  input  wire track_t     trk,
  input  wire logic       out_tready,
  output logic            in_tready,
  output logic            out_tvalid,
  output logic [95:0]     out_tdata,
  output logic            out_tlast,
  output logic            out_tuser
);

  logic        valid_r, valid_nxt;
  logic [95:0] data_r;
  logic        last_r;
  logic        user_r;

  // A new request may enter whenever the held result leaves or none is held.
  assign in_tready = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (res.emit) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, highest field first.
  always_ff @(posedge clk) begin
    if (res.emit) begin
      data_r <= {trk.min_row, trk.min_col, trk.min_value,
                 trk.max_row, trk.max_col, trk.max_value,
                 res.status, res.value, res.addr};
      last_r <= res.done;
      user_r <= res.pixel_valid;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;
  assign out_tuser  = user_r;

  // A result is never loaded while the held one is still blocked.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_tready) |-> !res.emit)
    else $error("result overwritten while stalled");

  // Every held result is either a pixel write or a packet end.
  a_content: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (user_r || last_r))
    else $error("empty result presented");

  // A pixel write carries the good status.
  a_user_status: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && user_r) |-> data_r[33:31] == ST_OK)
    else $error("pixel write with bad status");

endmodule

`default_nettype wire

// ----- rtl/core/thermal_video_packet_assembler_top.sv -----
// Top level of the thermal video packet assembler: parser, extremes tracker, result register.
// Depends on tvpa_pkg, tvpa_parse, tvpa_track and tvpa_out.
//
// Channel  Direction  Contents
// in_*     slave      one packet byte per request, flags in tuser
// out_*    master     frame write and/or packet status, tlast on the packet's last byte
//
// A byte is accepted every cycle while results are taken.
// Each result is presented in the cycle after its byte is accepted, from the result register.
// Bytes that produce no result still update the packet state and are never stalled
// unless a held result is blocked by out_tready.
// Reset is synchronous and active low; no clearing pass is needed after it.
`default_nettype none

module thermal_video_packet_assembler_top import tvpa_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [7:0] byte_value, [13:8] expected_line, [16:14] expected_segment, [23:17] zero
  input  wire logic [23:0] in_tdata,
  // [0] first_of_packet, [1] new_frame
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [14:0] pixel_address, [30:15] pixel_value, [33:31] status, [49:34] max_value,
  // [57:50] max_column, [64:58] max_row, [80:65] min_value, [88:81] min_column,
  // [95:89] min_row
  output logic [95:0]      out_tdata,
  // packet_done
  output logic             out_tlast,
  // [0] pixel_valid
  output logic             out_tuser
);

  logic       acc;
  pix_req_t   pix;
  parse_res_t res;
  track_t     trk;

  assign acc = in_tvalid && in_tready;

  // Header checks, byte counting and pixel assembly.
  tvpa_parse u_parse (
    .clk              (clk),
    .rst_n            (rst_n),
    .acc              (acc),
    .byte_value       (in_tdata[7:0]),
    .first_of_packet  (in_tuser[0]),
    .expected_line    (in_tdata[13:8]),
    .expected_segment (in_tdata[16:14]),
    .pix              (pix),
    .res              (res)
  );

  // Frame extremes.
  tvpa_track u_track (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (acc && in_tuser[1]),
    .pix   (pix),
    .trk   (trk)
  );

  // Result register and handshake.
  tvpa_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .trk        (trk),
    .out_tready (out_tready),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

// ----- bench/tb_thermal_video_packet_assembler_top.sv -----
// Self-checking bench for thermal_video_packet_assembler_top: packet bytes in, frame writes out.
// Depends on tvpa_pkg and the assembler RTL; an internal model predicts every result request.
`timescale 1ns / 1ps

module tb_thermal_video_packet_assembler_top;
  import tvpa_pkg::*;

  // One packet byte with its side-band flags.
  typedef struct {
    logic [7:0] data;
    logic       first;
    logic       clr;
    logic [5:0] line;
    logic [2:0] seg;
  } pkt_byte_t;

  // One frame write and/or end-of-packet status.
  typedef struct {
    logic        wr;
    logic [14:0] addr;
    logic [15:0] value;
    logic        done;
    status_t     status;
    logic [15:0] max_value;
    logic [7:0]  max_col;
    logic [6:0]  max_row;
    logic [15:0] min_value;
    logic [7:0]  min_col;
    logic [6:0]  min_row;
  } frame_event_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        rx_hold = 1'b0;

  pkt_byte_t    spi_bytes[$];
  frame_event_t frame_events[$];
  int unsigned  bytes_accepted = 0;
  int unsigned  writes_seen = 0;
  int unsigned  packets_ended = 0;
  int unsigned  mismatches = 0;

  // Model state of the assembler.
  logic [7:0]  pos;
  logic [7:0]  hdr0;
  logic [5:0]  lat_line;
  logic [2:0]  lat_seg;
  status_t     pkt_status;
  logic        stop;
  logic [7:0]  hi_byte;
  logic [15:0] run_max;
  logic [7:0]  run_max_col;
  logic [6:0]  run_max_row;
  logic [15:0] run_min;
  logic [7:0]  run_min_col;
  logic [6:0]  run_min_row;

  thermal_video_packet_assembler_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #2 clk = ~clk;

  // Prints one line per differing field and counts it.
  task automatic flag_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      mismatches++;
      $display("[%0t] MISMATCH %s: got %0d, want %0d", $realtime, name, got, want);
    end
  endtask

  function automatic void clear_extremes();
    run_max = '0;
    run_max_col = '0;
    run_max_row = '0;
    run_min = MIN_CLEAR;
    run_min_col = '0;
    run_min_row = '0;
  endfunction

  // Advances the packet state by one byte; returns 1 when a result request is due.
  function automatic bit assemble_byte(input pkt_byte_t b, output frame_event_t ev);
    logic [7:0]  idx;
    logic [7:0]  p;
    logic [15:0] v;
    logic [1:0]  slot;
    int          col;
    int          row;
    bit          wr;

    wr = 1'b0;
    ev.addr = '0;
    ev.value = '0;
    if (b.clr) begin
      clear_extremes();
    end
    if (b.first) begin
      pos = '0;
      lat_line = b.line;
      lat_seg = b.seg;
      pkt_status = ST_OK;
      stop = 1'b0;
      hi_byte = '0;
    end
    if (pos >= PKT_BYTES) begin
      return 1'b0;
    end
    idx = pos;
    pos = pos + 8'd1;

    if (idx == 8'd0) begin
      hdr0 = b.data;
      if (b.data[3:0] == DISCARD_NIBBLE) begin
        pkt_status = ST_DISCARD;
      end
    end else if (idx == 8'd1) begin
      // Line check, then the segment check that only line 20 carries.
      if (pkt_status == ST_OK) begin
        if (b.data != {2'b00, lat_line} || lat_line >= LINE_COUNT) begin
          pkt_status = ST_LINE;
        end else if (lat_line == SEG_CHECK_LINE) begin
          if (hdr0[7:4] == 4'd0) begin
            pkt_status = ST_SEGZERO;
          end else if (hdr0[7:4] != {1'b0, lat_seg}) begin
            pkt_status = ST_SEGMISMATCH;
          end
        end
      end
    end else if (idx >= HDR_BYTES) begin
      p = idx - HDR_BYTES;
      if (!p[0]) begin
        hi_byte = b.data;
      end else if (pkt_status == ST_OK && !stop) begin
        v = {hi_byte, b.data};
        slot = lat_seg[1:0] + 2'd3;
        col = (lat_line[0] ? int'(LINE_PIXELS) : 0) + int'(p >> 1);
        row = int'(slot) * int'(SEG_ROWS) + int'(lat_line >> 1);
        if (v > run_max) begin
          run_max = v;
          run_max_col = col[7:0];
          run_max_row = row[6:0];
        end
        if (v < run_min) begin
          run_min = v;
          run_min_col = col[7:0];
          run_min_row = row[6:0];
        end
        // A zero pixel ends pixel handling for the rest of the packet.
        if (v == 16'd0) begin
          stop = 1'b1;
          pkt_status = ST_ZEROPIX;
        end else begin
          wr = 1'b1;
          row = row * int'(FRAME_COLS) + col;
          ev.addr = row[14:0];
          ev.value = v;
        end
      end
    end

    ev.wr = wr;
    ev.done = (idx == PKT_BYTES - 8'd1);
    ev.status = pkt_status;
    ev.max_value = run_max;
    ev.max_col = run_max_col;
    ev.max_row = run_max_row;
    ev.min_value = run_min;
    ev.min_col = run_min_col;
    ev.min_row = run_min_row;
    return wr || ev.done;
  endfunction

  task automatic push_byte(logic [7:0] data, logic first, logic clr, logic [5:0] line,
                           logic [2:0] seg);
    pkt_byte_t b;
    b.data = data;
    b.first = first;
    b.clr = clr;
    b.line = line;
    b.seg = seg;
    spi_bytes.push_back(b);
  endtask

  function automatic logic [15:0] pick_pixel();
    case ($urandom_range(0, 7))
      0: return 16'hFFFF;
      1: return 16'h0001;
      2: return 16'($urandom_range(1, 255));
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  // Queues one packet of len bytes; zero_at forces a zero pixel at that index.
  task automatic push_packet(logic [7:0] id_hi, logic [7:0] id_lo, logic [5:0] line,
                             logic [2:0] seg, logic clr, int len, int zero_at);
    logic [15:0] pix;
    logic [7:0]  data;

    pix = '0;
    for (int i = 0; i < len; i++) begin
      if (i == 0) begin
        data = id_hi;
      end else if (i == 1) begin
        data = id_lo;
      end else if (i < 4) begin
        data = 8'($urandom);
      end else if (i % 2 == 0) begin
        pix = ((i - 4) / 2 == zero_at) ? 16'd0 : pick_pixel();
        data = pix[15:8];
      end else begin
        data = pix[7:0];
      end
      // Header fields only matter on the first byte; the rest carry noise there.
      if (i == 0) begin
        push_byte(data, 1'b1, clr, line, seg);
      end else begin
        push_byte(data, 1'b0, $urandom_range(0, 299) == 0, 6'($urandom), 3'($urandom));
      end
    end
  endtask

  // Stimulus: directed header cases first, then random packets.
  initial begin : fill_stimulus
    logic [5:0] line;
    logic [2:0] seg;
    logic [7:0] id_hi;
    logic [7:0] id_lo;
    int         len;

    pos = '0;
    hdr0 = '0;
    lat_line = '0;
    lat_seg = 3'd1;
    pkt_status = ST_OK;
    stop = 1'b0;
    hi_byte = '0;
    clear_extremes();

    // Bytes before any first mark form a packet on line 0, segment 1.
    push_byte(8'h10, 1'b0, 1'b0, 6'd33, 3'd6);
    push_byte(8'h00, 1'b0, 1'b0, 6'd12, 3'd2);
    push_byte(8'hA5, 1'b0, 1'b0, 6'd0, 3'd0);
    push_byte(8'h5A, 1'b0, 1'b0, 6'd63, 3'd7);
    push_byte(8'hFF, 1'b0, 1'b0, 6'd0, 3'd0);
    push_byte(8'hFF, 1'b0, 1'b0, 6'd0, 3'd0);
    // Discard nibble, line mismatch, line beyond 59, segment zero and mismatch.
    push_packet(8'h1F, 8'd3, 6'd3, 3'd1, 1'b1, 6, -1);
    push_packet(8'h20, 8'd6, 6'd5, 3'd2, 1'b0, 6, -1);
    push_packet(8'h30, 8'd63, 6'd63, 3'd3, 1'b0, 6, -1);
    push_packet(8'h05, 8'd20, 6'd20, 3'd2, 1'b0, 6, -1);
    push_packet(8'h35, 8'd20, 6'd20, 3'd2, 1'b0, 6, -1);
    // Good line-20 packet whose second pixel is zero.
    push_packet(8'h40, 8'd20, 6'd20, 3'd4, 1'b1, 10, 1);

    while (spi_bytes.size() < 1850) begin
      line = 6'($urandom_range(0, 59));
      seg = 3'($urandom_range(1, 4));
      if ($urandom_range(0, 3) == 0) begin
        line = SEG_CHECK_LINE;
      end
      id_hi = {(line == SEG_CHECK_LINE) ? {1'b0, seg} : 4'($urandom), 4'($urandom_range(0, 14))};
      id_lo = {2'b00, line};
      if ($urandom_range(0, 9) == 0) begin
        // Broken header: any line, any segment, any id.
        line = 6'($urandom);
        seg = 3'($urandom);
        id_hi = 8'($urandom);
        id_lo = $urandom_range(0, 1) ? {2'b00, line} : 8'($urandom);
      end
      len = $urandom_range(0, 1) ? int'(PKT_BYTES) : $urandom_range(1, 163);
      push_packet(id_hi, id_lo, line, seg, $urandom_range(0, 3) == 0, len,
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 79) : -1);
      // Stray bytes after a finished packet must be ignored.
      if (len == int'(PKT_BYTES) && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          push_byte(8'($urandom), 1'b0, 1'b0, 6'($urandom), 3'($urandom));
        end
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Sender: offers queued bytes and models each accepted one.
  always @(posedge clk) begin : drive_bytes
    static pkt_byte_t on_wire;
    static int        tx_gap = 0;
    static bit        tx_calm = 1'b0;
    frame_event_t     ev;

    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        bytes_accepted++;
        if (assemble_byte(on_wire, ev)) begin
          frame_events.push_back(ev);
        end
      end
      if ($urandom_range(0, 49) == 0) begin
        tx_calm = !tx_calm;
      end
      if (!in_tvalid || in_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (spi_bytes.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (!tx_calm && spi_bytes.size() > 150 && $urandom_range(0, 5) == 0) begin
          tx_gap = $urandom_range(0, 2);
          in_tvalid <= 1'b0;
        end else begin
          on_wire = spi_bytes.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {7'd0, on_wire.seg, on_wire.line, on_wire.data};
          in_tuser <= {on_wire.clr, on_wire.first};
        end
      end
    end
  end

  // Receiver: random back-pressure and field-by-field comparison of each result.
  always @(posedge clk) begin : watch_results
    static int    rx_gap = 0;
    static bit    rx_calm = 1'b0;
    frame_event_t ev;

    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (frame_events.size() == 0) begin
          flag_field("result with nothing pending", 32'd1, 32'd0);
        end else begin
          ev = frame_events.pop_front();
          if (out_tuser) begin
            writes_seen++;
          end
          if (out_tlast) begin
            packets_ended++;
          end
          flag_field("pixel_valid", out_tuser, ev.wr);
          flag_field("pixel_address", out_tdata[14:0], ev.addr);
          flag_field("pixel_value", out_tdata[30:15], ev.value);
          flag_field("packet_done", out_tlast, ev.done);
          flag_field("status", out_tdata[33:31], ev.status);
          flag_field("max_value", out_tdata[49:34], ev.max_value);
          flag_field("max_column", out_tdata[57:50], ev.max_col);
          flag_field("max_row", out_tdata[64:58], ev.max_row);
          flag_field("min_value", out_tdata[80:65], ev.min_value);
          flag_field("min_column", out_tdata[88:81], ev.min_col);
          flag_field("min_row", out_tdata[95:89], ev.min_row);
        end
      end
      if ($urandom_range(0, 49) == 0) begin
        rx_calm = !rx_calm;
      end
      if (rx_hold) begin
        out_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_tready <= 1'b0;
      end else if (!rx_calm && spi_bytes.size() > 150 && $urandom_range(0, 5) == 0) begin
        rx_gap = $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Long receiver hold-off so the result register fills and the input stalls.
  initial begin : hold_receiver
    wait (rst_n === 1'b1);
    while (bytes_accepted < 400) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (300) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // End of run: drain pending results, then report.
  initial begin : finish_run
    int drain;

    drain = 0;
    wait (rst_n === 1'b1);
    while (spi_bytes.size() != 0 || in_tvalid) @(posedge clk);
    while (frame_events.size() != 0 && drain < 2000) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    if (frame_events.size() != 0) begin
      flag_field("results never delivered", 32'd0, frame_events.size());
    end
    $display("Run covered %0d bytes: %0d frame writes and %0d completed packets checked.",
             bytes_accepted, writes_seen, packets_ended);
    $display("Field mismatches: %0d.", mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hard stop in case the handshake hangs.
  initial begin : watchdog
    #(1_000_000);
    $display("Timeout: run did not finish, %0d bytes accepted.", bytes_accepted);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
